>>> sv/liwv_pkg.sv
// Package for the logit IWLS working-value core: default sizes, Q30 constants,
// register indexes and the elaboration-time series used to fill the exp/log tables.
// No dependencies.
package liwv_pkg;

    localparam int FRACTION_BITS_DEF     = 16;
    localparam int EXP_TABLE_ENTRIES_DEF = 256;

    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic [63:0] LN2_Q30   = 64'd744261118;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WEIGHTS_ONE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPUTE_LL  = 1'd1;

    // exp(-y), y in Q30 within [0, ln 2], result Q30
    function automatic logic [63:0] series_exp_neg(input logic [63:0] y);
        logic [63:0] term;
        logic [63:0] plus;
        logic [63:0] minus;
        term  = Q30_ONE;
        plus  = Q30_ONE;
        minus = 64'd0;
        for (int k = 1; k <= 18; k++) begin
            term = ((term * y) >> 30) / 64'(k);
            if (k[0]) minus = minus + term;
            else plus = plus + term;
        end
        return plus - minus;
    endfunction

    // 2*atanh(s) with s = z/(2+z) already formed, result Q30 = ln(1+z)
    function automatic logic [63:0] series_log1p_s(input logic [63:0] s);
        logic [63:0] s2;
        logic [63:0] p;
        logic [63:0] sum;
        s2  = (s * s) >> 30;
        p   = s;
        sum = s;
        for (int k = 3; k <= 31; k += 2) begin
            p   = (p * s2) >> 30;
            sum = sum + p / 64'(k);
        end
        return sum << 1;
    endfunction

endpackage

>>> sv/logit_iwls_working_values_core.sv
// Logit IWLS working values: mean, variance, working weight/response and
// log-likelihood term per observation, fully pipelined. Uses liwv_pkg.
//
//  channel   signals                                          handshake
//  config    i_cfg_we, i_cfg_idx, i_cfg_data                  write on i_cfg_we
//  item in   i_response_value, i_linear_predictor,             start && !busy
//            i_prior_weight
//  item out  o_working_weight, o_working_response,            o_done, one cycle
//            o_loglik_term
//
// One item per cycle; the pipeline consists of the two restoring dividers (F+1 and
// NW2 = max(17,F+1)+F+1 stages) plus 20 stages of exp, log1p, variance, multiply and
// saturation. busy stays low: the receiver cannot stall and nothing in the pipe ever
// waits. Synchronous reset clears the valid bits and returns the configuration
// registers to weights-one off, log-likelihood on; items in flight at reset are dropped.
module logit_iwls_working_values_core #(
    parameter int FRACTION_BITS     = liwv_pkg::FRACTION_BITS_DEF,
    parameter int EXP_TABLE_ENTRIES = liwv_pkg::EXP_TABLE_ENTRIES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [liwv_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                           i_cfg_data,
    input  logic                           start,
    output logic                           busy,
    input  logic [16:0]                    i_response_value,
    input  logic signed [31:0]             i_linear_predictor,
    input  logic [24:0]                    i_prior_weight,
    output logic                           o_done,
    output logic [22:0]                    o_working_weight,
    output logic signed [31:0]             o_working_response,
    output logic signed [47:0]             o_loglik_term
);

    localparam int F   = FRACTION_BITS;
    localparam int N   = EXP_TABLE_ENTRIES;
    localparam int NB  = $clog2(N + 1);
    localparam int KW  = 33 - F;
    localparam int PCW = F + NB;
    localparam int DW  = ((50 > 34 + F) ? 50 : 34 + F) + 1;
    localparam int MW  = DW - F + 1;
    localparam int LO  = MW / 2;
    localparam int HI  = MW - LO;
    localparam int PSW = MW + 26;
    localparam int PW  = PSW - F;
    localparam int EW  = (PW > 49) ? PW : 49;
    localparam int NW1 = 31 + F;
    localparam int D1  = F + 1;
    localparam int VW  = F - 1;
    localparam int AW  = (17 > F + 1) ? 17 : F + 1;
    localparam int DYW = AW + 1;
    localparam int NW2 = AW + F + 1;
    localparam int D2  = NW2;
    localparam int SW  = ((NW2 + 1 > 32) ? NW2 + 1 : 32) + 1;
    localparam int LAT = 21 + F + NW2;

    localparam longint ONE_L = 64'sd1 <<< F;
    localparam logic [F:0] ONE    = (F + 1)'(ONE_L);
    localparam logic [F:0] MU_LO  = (F + 1)'((ONE_L + 500) / 1000);
    localparam logic [F:0] MU_HI  = (F + 1)'((999 * ONE_L + 500) / 1000);
    localparam logic signed [33:0] X_TEN   = 34'(10 * ONE_L);
    localparam logic [32:0]        LP_HALF = 33'(64'd1 << (29 - F));
    localparam logic [DW:0]        D_HALF  = (DW + 1)'(64'd1 << (F - 1));
    localparam logic [PSW-1:0]     P_HALF  = PSW'(64'd1 << (F - 1));
    localparam logic [EW-1:0]      LL_LIM  = EW'(64'd1 << 47);
    localparam logic signed [SW-1:0] WR_HI = SW'(32'sh7fffffff);
    localparam logic signed [SW-1:0] WR_LO = SW'(32'sh80000000);

    typedef struct packed {
        logic [16:0]        y;
        logic signed [31:0] x;
        logic [24:0]        w;
        logic               cl;
    } t_obs;

    // constant tables
    logic [30:0] exp_tab [0:N];
    logic [30:0] log_tab [0:N];

    for (genvar g = 0; g <= N; g++) begin : g_tab
        localparam logic [63:0] EY = (64'(g) * liwv_pkg::LN2_Q30) / 64'(EXP_TABLE_ENTRIES);
        localparam logic [63:0] LZ = (64'(g) << 30) / 64'(EXP_TABLE_ENTRIES);
        localparam logic [63:0] LS = (LZ << 30) / (64'd2 * liwv_pkg::Q30_ONE + LZ);
        assign exp_tab[g] = 31'(liwv_pkg::series_exp_neg(EY));
        assign log_tab[g] = 31'(liwv_pkg::series_log1p_s(LS));
    end

    // configuration
    logic r_cfg_wao;
    logic r_cfg_cl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_wao <= 1'b0;
            r_cfg_cl  <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                liwv_pkg::CFG_WEIGHTS_ONE: r_cfg_wao <= i_cfg_data;
                liwv_pkg::CFG_COMPUTE_LL:  r_cfg_cl  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // front stages: exp(-|x|), log1p and the log-likelihood term
    logic r_a_vld, r_b_vld, r_c_vld, r_d_vld, r_e_vld, r_f_vld, r_g_vld;
    logic r_h_vld, r_i_vld, r_j_vld, r_k_vld, r_l_vld, r_m_vld, r_n_vld;
    t_obs r_a_obs, r_b_obs, r_c_obs, r_d_obs, r_e_obs, r_f_obs, r_g_obs;
    t_obs r_h_obs, r_i_obs, r_j_obs, r_k_obs, r_l_obs, r_m_obs, r_n_obs;

    logic [62:0]        r_b_prod;
    logic [PCW-1:0]     r_c_pos;
    logic [KW-1:0]      r_c_k, r_d_k, r_e_k;
    logic [30:0]        r_d_t0, r_d_dt, r_e_t0;
    logic [F-1:0]       r_d_r;
    logic [30+F:0]      r_e_m;
    logic [30:0]        r_f_e, r_g_e, r_h_e, r_i_e, r_j_e, r_k_e, r_l_e, r_m_e, r_n_e;
    logic [30+NB:0]     r_g_pos;
    logic [30:0]        r_h_l0, r_h_dl, r_i_l0;
    logic [29:0]        r_h_r;
    logic [60:0]        r_i_m;
    logic signed [33:0] r_j_s, r_k_s;
    logic signed [49:0] r_k_yx;
    logic [MW-1:0]      r_l_m;
    logic               r_l_neg, r_m_neg;
    logic [LO+24:0]     r_m_plo;
    logic [HI+24:0]     r_m_phi;
    logic [47:0]        r_n_ll;

    logic [31:0]        ax;
    logic [32:0]        u;
    logic [NB-1:0]      ti;
    logic [NB-1:0]      ti1;
    logic [30:0]        vv;
    logic [NB:0]        li;
    logic               llast;
    logic [NB-1:0]      lx0;
    logic [NB-1:0]      lx1;
    logic [32:0]        lsum;
    logic [F+2:0]       lp;
    logic signed [33:0] x34;
    logic signed [33:0] s_n;
    logic signed [DW-1:0] diff;
    logic [DW-1:0]      mag;
    logic [DW:0]        mds;
    logic [PSW-1:0]     psum;
    logic [EW-1:0]      pe;
    logic [47:0]        ll_n;

    always_comb begin
        ax  = r_a_obs.x[31] ? (~r_a_obs.x + 1'b1) : r_a_obs.x;
        u   = r_b_prod[62:30];
        ti  = r_c_pos[PCW-1:F];
        ti1 = NB'(ti + 1'b1);
        vv  = r_e_t0 - r_e_m[30+F:F];
        li    = r_g_pos[30+NB:30];
        llast = (li >= (NB + 1)'(N));
        lx0   = llast ? NB'(N) : li[NB-1:0];
        lx1   = llast ? NB'(N) : NB'(li + 1'b1);
        lsum = 33'(r_i_l0) + 33'(r_i_m[60:30]) + LP_HALF;
        lp   = lsum[32:30-F];
        x34  = 34'(r_i_obs.x);
        if (x34 >= X_TEN) s_n = x34;
        else s_n = ((x34 > 0) ? x34 : 34'sd0) + $signed(34'(lp));
        diff = DW'(r_k_yx) - (DW'(r_k_s) <<< F);
        mag  = diff[DW-1] ? (~diff + 1'b1) : diff;
        mds  = (DW + 1)'(mag) + D_HALF;
        psum = PSW'(r_m_plo) + (PSW'(r_m_phi) << LO) + P_HALF;
        pe   = EW'(psum[PSW-1:F]);
        if (!r_m_obs.cl) ll_n = 48'd0;
        else if (r_m_neg) ll_n = (pe > LL_LIM) ? 48'h8000_0000_0000 : 48'(~pe + 1'b1);
        else ll_n = (pe >= LL_LIM) ? 48'h7fff_ffff_ffff : pe[47:0];
    end

    always_ff @(posedge i_clk) begin
        r_a_obs.y  <= i_response_value;
        r_a_obs.x  <= i_linear_predictor;
        r_a_obs.w  <= r_cfg_wao ? 25'(ONE_L) : i_prior_weight;
        r_a_obs.cl <= r_cfg_cl;
        r_b_obs <= r_a_obs;
        r_b_prod <= 63'(ax) * 63'(liwv_pkg::LOG2E_Q30);
        r_c_obs <= r_b_obs;
        r_c_k   <= u[32:F];
        r_c_pos <= PCW'(u[F-1:0]) * PCW'(N);
        r_d_obs <= r_c_obs;
        r_d_k   <= r_c_k;
        r_d_t0  <= exp_tab[ti];
        r_d_dt  <= exp_tab[ti] - exp_tab[ti1];
        r_d_r   <= r_c_pos[F-1:0];
        r_e_obs <= r_d_obs;
        r_e_k   <= r_d_k;
        r_e_t0  <= r_d_t0;
        r_e_m   <= (31 + F)'(r_d_dt) * (31 + F)'(r_d_r);
        r_f_obs <= r_e_obs;
        r_f_e   <= (r_e_k >= KW'(31)) ? 31'd0 : (vv >> r_e_k[4:0]);
        r_g_obs <= r_f_obs;
        r_g_e   <= r_f_e;
        r_g_pos <= (31 + NB)'(r_f_e) * (31 + NB)'(N);
        r_h_obs <= r_g_obs;
        r_h_e   <= r_g_e;
        r_h_l0  <= log_tab[lx0];
        r_h_dl  <= log_tab[lx1] - log_tab[lx0];
        r_h_r   <= llast ? 30'd0 : r_g_pos[29:0];
        r_i_obs <= r_h_obs;
        r_i_e   <= r_h_e;
        r_i_l0  <= r_h_l0;
        r_i_m   <= 61'(r_h_dl) * 61'(r_h_r);
        r_j_obs <= r_i_obs;
        r_j_e   <= r_i_e;
        r_j_s   <= s_n;
        r_k_obs <= r_j_obs;
        r_k_e   <= r_j_e;
        r_k_s   <= r_j_s;
        r_k_yx  <= $signed({1'b0, r_j_obs.y}) * r_j_obs.x;
        r_l_obs <= r_k_obs;
        r_l_e   <= r_k_e;
        r_l_m   <= mds[DW:F];
        r_l_neg <= diff[DW-1];
        r_m_obs <= r_l_obs;
        r_m_e   <= r_l_e;
        r_m_neg <= r_l_neg;
        r_m_plo <= (LO + 25)'(r_l_m[LO-1:0]) * (LO + 25)'(r_l_obs.w);
        r_m_phi <= (HI + 25)'(r_l_m[MW-1:LO]) * (HI + 25)'(r_l_obs.w);
        r_n_obs <= r_m_obs;
        r_n_e   <= r_m_e;
        r_n_ll  <= ll_n;
    end

    // mean divider: mu = round(num / (2^30 + e))
    logic              r_d1_vld [0:D1];
    t_obs              r_d1_obs [0:D1];
    logic [47:0]       r_d1_ll  [0:D1];
    logic [31:0]       r_d1_den [0:D1];
    logic [31:0]       r_d1_rem [0:D1];
    logic [F:0]        r_d1_nlo [0:D1];
    logic [F:0]        r_d1_q   [0:D1];

    logic [31:0]    den0;
    logic [NW1-1:0] num1;

    always_comb begin
        den0 = 32'(r_n_e) + 32'h4000_0000;
        if (!r_n_obs.x[31]) num1 = (NW1'(1) << (30 + F)) + NW1'(den0 >> 1);
        else num1 = (NW1'(r_n_e) << F) + NW1'(den0 >> 1);
    end

    always_ff @(posedge i_clk) begin
        r_d1_obs[0] <= r_n_obs;
        r_d1_ll[0]  <= r_n_ll;
        r_d1_den[0] <= den0;
        r_d1_rem[0] <= 32'(num1[NW1-1:F+1]);
        r_d1_nlo[0] <= num1[F:0];
        r_d1_q[0]   <= '0;
    end

    for (genvar j = 1; j <= D1; j++) begin : g_d1
        logic [32:0] t;
        logic        ge;
        always_comb begin
            t  = {r_d1_rem[j-1], r_d1_nlo[j-1][F]};
            ge = (t >= {1'b0, r_d1_den[j-1]});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_d1_vld[j] <= 1'b0;
            else r_d1_vld[j] <= r_d1_vld[j-1];
        end
        always_ff @(posedge i_clk) begin
            r_d1_obs[j] <= r_d1_obs[j-1];
            r_d1_ll[j]  <= r_d1_ll[j-1];
            r_d1_den[j] <= r_d1_den[j-1];
            r_d1_rem[j] <= ge ? 32'(t - {1'b0, r_d1_den[j-1]}) : t[31:0];
            r_d1_nlo[j] <= {r_d1_nlo[j-1][F-1:0], 1'b0};
            r_d1_q[j]   <= {r_d1_q[j-1][F-1:0], ge};
        end
    end

    // variance and working weight
    logic                  r_p_vld, r_q_vld, r_r_vld;
    t_obs                  r_p_obs, r_q_obs;
    logic [47:0]           r_p_ll, r_q_ll, r_r_ll;
    logic [F:0]            r_p_mu;
    logic [2*F+1:0]        r_p_mv;
    logic [VW-1:0]         r_q_v, r_r_v;
    logic signed [DYW-1:0] r_q_dy, r_r_dy;
    logic signed [31:0]    r_r_x;
    logic [24+VW:0]        r_r_wwp;

    logic [F:0]            mu_c;
    logic [2*F+2:0]        vs;
    logic [VW-1:0]         v_n;

    always_comb begin
        if (r_d1_q[D1] > MU_HI) mu_c = MU_HI;
        else if (r_d1_q[D1] < MU_LO) mu_c = MU_LO;
        else mu_c = r_d1_q[D1];
        vs  = (2 * F + 3)'(r_p_mv) + (2 * F + 3)'(ONE >> 1);
        v_n = vs[F+VW-1:F];
        if (v_n == '0) v_n = VW'(1);
    end

    always_ff @(posedge i_clk) begin
        r_p_obs <= r_d1_obs[D1];
        r_p_ll  <= r_d1_ll[D1];
        r_p_mu  <= mu_c;
        r_p_mv  <= (2 * F + 2)'(mu_c) * (2 * F + 2)'(ONE - mu_c);
        r_q_obs <= r_p_obs;
        r_q_ll  <= r_p_ll;
        r_q_v   <= v_n;
        r_q_dy  <= $signed(DYW'(r_p_obs.y)) - $signed(DYW'(r_p_mu));
        r_r_x   <= r_q_obs.x;
        r_r_ll  <= r_q_ll;
        r_r_v   <= r_q_v;
        r_r_dy  <= r_q_dy;
        r_r_wwp <= (25 + VW)'(r_q_obs.w) * (25 + VW)'(r_q_v);
    end

    // working-response divider: round((y - mu) * ONE / v), half away from zero
    logic               r_d2_vld [0:D2];
    logic signed [31:0] r_d2_x   [0:D2];
    logic [47:0]        r_d2_ll  [0:D2];
    logic [22:0]        r_d2_ww  [0:D2];
    logic               r_d2_neg [0:D2];
    logic [VW-1:0]      r_d2_v   [0:D2];
    logic [VW-1:0]      r_d2_rem [0:D2];
    logic [NW2-1:0]     r_d2_num [0:D2];
    logic [NW2-1:0]     r_d2_q   [0:D2];

    logic [25+VW:0]     wws;
    logic [24:0]        wwq;
    logic [AW-1:0]      ady;

    always_comb begin
        wws = (26 + VW)'(r_r_wwp) + (26 + VW)'(ONE >> 1);
        wwq = wws[25+VW:F];
        ady = r_r_dy[DYW-1] ? AW'(-r_r_dy) : AW'(r_r_dy);
    end

    always_ff @(posedge i_clk) begin
        r_d2_x[0]   <= r_r_x;
        r_d2_ll[0]  <= r_r_ll;
        r_d2_ww[0]  <= (wwq > 25'd4194304) ? 23'h40_0000 : wwq[22:0];
        r_d2_neg[0] <= r_r_dy[DYW-1];
        r_d2_v[0]   <= r_r_v;
        r_d2_rem[0] <= '0;
        r_d2_num[0] <= (NW2'(ady) << F) + NW2'(r_r_v >> 1);
        r_d2_q[0]   <= '0;
    end

    for (genvar j = 1; j <= D2; j++) begin : g_d2
        logic [VW:0] t;
        logic        ge;
        always_comb begin
            t  = {r_d2_rem[j-1], r_d2_num[j-1][NW2-1]};
            ge = (t >= {1'b0, r_d2_v[j-1]});
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) r_d2_vld[j] <= 1'b0;
            else r_d2_vld[j] <= r_d2_vld[j-1];
        end
        always_ff @(posedge i_clk) begin
            r_d2_x[j]   <= r_d2_x[j-1];
            r_d2_ll[j]  <= r_d2_ll[j-1];
            r_d2_ww[j]  <= r_d2_ww[j-1];
            r_d2_neg[j] <= r_d2_neg[j-1];
            r_d2_v[j]   <= r_d2_v[j-1];
            r_d2_rem[j] <= ge ? VW'(t - {1'b0, r_d2_v[j-1]}) : t[VW-1:0];
            r_d2_num[j] <= {r_d2_num[j-1][NW2-2:0], 1'b0};
            r_d2_q[j]   <= {r_d2_q[j-1][NW2-2:0], ge};
        end
    end

    // output stage
    logic               r_t_vld;
    logic [22:0]        r_t_ww;
    logic signed [31:0] r_t_wr;
    logic signed [47:0] r_t_ll;

    logic signed [SW-1:0] qs;
    logic signed [SW-1:0] wr_s;

    always_comb begin
        qs   = $signed(SW'(r_d2_q[D2]));
        wr_s = SW'(r_d2_x[D2]) + (r_d2_neg[D2] ? -qs : qs);
    end

    always_ff @(posedge i_clk) begin
        r_t_ww <= r_d2_ww[D2];
        r_t_ll <= r_d2_ll[D2];
        if (wr_s > WR_HI) r_t_wr <= 32'sh7fffffff;
        else if (wr_s < WR_LO) r_t_wr <= 32'sh80000000;
        else r_t_wr <= wr_s[31:0];
    end

    // valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld     <= 1'b0;
            r_b_vld     <= 1'b0;
            r_c_vld     <= 1'b0;
            r_d_vld     <= 1'b0;
            r_e_vld     <= 1'b0;
            r_f_vld     <= 1'b0;
            r_g_vld     <= 1'b0;
            r_h_vld     <= 1'b0;
            r_i_vld     <= 1'b0;
            r_j_vld     <= 1'b0;
            r_k_vld     <= 1'b0;
            r_l_vld     <= 1'b0;
            r_m_vld     <= 1'b0;
            r_n_vld     <= 1'b0;
            r_d1_vld[0] <= 1'b0;
            r_p_vld     <= 1'b0;
            r_q_vld     <= 1'b0;
            r_r_vld     <= 1'b0;
            r_d2_vld[0] <= 1'b0;
            r_t_vld     <= 1'b0;
        end else begin
            r_a_vld     <= start && !busy;
            r_b_vld     <= r_a_vld;
            r_c_vld     <= r_b_vld;
            r_d_vld     <= r_c_vld;
            r_e_vld     <= r_d_vld;
            r_f_vld     <= r_e_vld;
            r_g_vld     <= r_f_vld;
            r_h_vld     <= r_g_vld;
            r_i_vld     <= r_h_vld;
            r_j_vld     <= r_i_vld;
            r_k_vld     <= r_j_vld;
            r_l_vld     <= r_k_vld;
            r_m_vld     <= r_l_vld;
            r_n_vld     <= r_m_vld;
            r_d1_vld[0] <= r_n_vld;
            r_p_vld     <= r_d1_vld[D1];
            r_q_vld     <= r_p_vld;
            r_r_vld     <= r_q_vld;
            r_d2_vld[0] <= r_r_vld;
            r_t_vld     <= r_d2_vld[D2];
        end
    end

    assign o_done             = r_t_vld;
    assign o_working_weight   = r_t_ww;
    assign o_working_response = r_t_wr;
    assign o_loglik_term      = r_t_ll;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start, LAT))
        else $error("result without an item accepted LAT cycles earlier");

    a_mu_clamp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> (r_p_mu >= MU_LO && r_p_mu <= MU_HI))
        else $error("mean outside clamp range");

    a_var_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_q_vld |-> (r_q_v != '0))
        else $error("zero variance reached divider");

    a_ww_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_working_weight <= 23'd4194304))
        else $error("working weight above saturation limit");

endmodule
